>>> design/pbp_pkg.sv
// shared constants, types and state codes of the perceptron branch predictor
package pbp_pkg;

    localparam int TABLE_INDEX_BITS = 10;
    localparam int HISTORY_LEN      = 59;
    localparam int WEIGHT_BITS      = 8;

    localparam int ROWS    = 1 << TABLE_INDEX_BITS;
    localparam int ROW_LEN = HISTORY_LEN + 1;
    localparam int ROW_W   = ROW_LEN * WEIGHT_BITS;

    localparam int PC_W  = 64;
    localparam int DP_W  = 14;
    localparam int THR_W = 10;
    localparam int THR_RESET = 127;

    // adder tree: groups of eight terms summed in the first stage
    localparam int GROUP   = 8;
    localparam int NGROUPS = (ROW_LEN + GROUP - 1) / GROUP;

    localparam int SUM_BASE_W = WEIGHT_BITS + $clog2(ROW_LEN + 1) + 1;
    localparam int SUM_W = (SUM_BASE_W > DP_W + 1) ? SUM_BASE_W : DP_W + 1;

    localparam int DP_MAX = (1 << (DP_W - 1)) - 1;
    localparam int DP_MIN = -(1 << (DP_W - 1));

    typedef logic [PC_W-1:0]               pc_t;
    typedef logic [TABLE_INDEX_BITS-1:0]   index_t;
    typedef logic [HISTORY_LEN-1:0]        hist_t;
    typedef logic [ROW_W-1:0]              row_t;
    typedef logic signed [WEIGHT_BITS-1:0] weight_t;
    typedef logic signed [SUM_W-1:0]       sum_t;
    typedef logic signed [DP_W-1:0]        dp_t;
    typedef logic [THR_W-1:0]              thr_t;

    typedef struct packed {
        logic load_partial;
        logic load_total;
    } sum_ctrl_t;

    typedef enum logic [4:0] {
        S_CLEAR = 5'b00001,
        S_IDLE  = 5'b00010,
        S_READ  = 5'b00100,
        S_ACC   = 5'b01000,
        S_UPD   = 5'b10000
    } state_t;

endpackage

>>> design/pbp_if.sv
// branch and result channels of the perceptron branch predictor
interface pbp_branch_if;
    import pbp_pkg::*;

    logic valid;
    logic ready;
    pc_t  pc;
    logic taken;

    modport source (output valid, output pc, output taken, input ready);
    modport sink   (input valid, input pc, input taken, output ready);
endinterface

interface pbp_result_if;
    import pbp_pkg::*;

    logic valid;
    logic ready;
    logic predicted_taken;
    dp_t  dot_product;
    logic trained;

    modport source (output valid, output predicted_taken, output dot_product,
                    output trained, input ready);
    modport sink   (input valid, input predicted_taken, input dot_product,
                    input trained, output ready);
endinterface

>>> design/pbp_ram.sv
// generic single-port-write, registered-read ram
module pbp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule

>>> design/pbp_sum.sv
// two-stage registered adder tree for the perceptron output
module pbp_sum (
    input  logic              clk,
    input  pbp_pkg::sum_ctrl_t ctrl,
    input  pbp_pkg::row_t     row,
    input  pbp_pkg::hist_t    hist,
    output pbp_pkg::sum_t     sum
);
    import pbp_pkg::*;

    sum_t part_next [NGROUPS];
    sum_t part_reg  [NGROUPS];
    sum_t total_next;
    sum_t total_reg;

    // each group adds up to eight weights, signed by their history bit
    always_comb
    begin
        sum_t acc;
        sum_t term;
        logic pos;
        term = '0;
        pos  = 1'b0;
        for (int g = 0; g < NGROUPS; g++)
        begin
            acc = '0;
            for (int k = 0; k < GROUP; k++)
            begin
                if (g * GROUP + k < ROW_LEN)
                begin
                    term = sum_t'($signed(row[(g * GROUP + k) * WEIGHT_BITS +: WEIGHT_BITS]));
                    if (g * GROUP + k == 0)
                    begin
                        pos = 1'b1;
                    end
                    else
                    begin
                        pos = hist[g * GROUP + k - 1];
                    end
                    acc = pos ? acc + term : acc - term;
                end
            end
            part_next[g] = acc;
        end
    end

    always_comb
    begin
        total_next = '0;
        for (int g = 0; g < NGROUPS; g++)
        begin
            total_next = total_next + part_reg[g];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load_partial)
        begin
            part_reg <= part_next;
        end
        if (ctrl.load_total)
        begin
            total_reg <= total_next;
        end
    end

    assign sum = total_reg;
endmodule

>>> design/pbp_train.sv
// saturating training update of one weight row
module pbp_train (
    input  pbp_pkg::row_t  row,
    input  pbp_pkg::hist_t hist,
    input  logic           taken,
    output pbp_pkg::row_t  new_row
);
    import pbp_pkg::*;

    localparam weight_t W_MAX = {1'b0, {(WEIGHT_BITS - 1){1'b1}}};
    localparam weight_t W_MIN = {1'b1, {(WEIGHT_BITS - 1){1'b0}}};

    always_comb
    begin
        weight_t w;
        logic    pos;
        logic    up;
        for (int i = 0; i < ROW_LEN; i++)
        begin
            w = weight_t'(row[i * WEIGHT_BITS +: WEIGHT_BITS]);
            if (i == 0)
            begin
                pos = 1'b1;
            end
            else
            begin
                pos = hist[i - 1];
            end
            // outcome times input is +1 when they agree
            up = (taken == pos);
            if (up)
            begin
                new_row[i * WEIGHT_BITS +: WEIGHT_BITS] = (w == W_MAX) ? w : w + weight_t'(1);
            end
            else
            begin
                new_row[i * WEIGHT_BITS +: WEIGHT_BITS] = (w == W_MIN) ? w : w - weight_t'(1);
            end
        end
    end
endmodule

>>> design/perceptron_branch_predictor.sv
// Perceptron branch predictor: one branch word in, one prediction word out. The
// low pc bits pick a row of the weight ram (bias plus one weight per history bit,
// one row per ram word); the row is read, summed in a two-stage adder tree,
// trained if needed and written back before the next branch is taken, so the
// block takes no new branch until the last one is through that read-sum-write
// loop on the single row ram. The result sits in an output register, so the next
// branch is accepted while it waits. After reset the ram is cleared one row per
// cycle, all 1024 rows at the default table size; no branch is accepted during
// that pass, threshold writes are taken at any time.
module perceptron_branch_predictor (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             threshold_we,
    input  pbp_pkg::thr_t    threshold_wdata,
    pbp_branch_if.sink       branch,
    pbp_result_if.source     result
);
    import pbp_pkg::*;

    state_t    state_reg, state_next;
    index_t    clr_cnt_reg, clr_cnt_next;
    thr_t      threshold_reg;
    hist_t     history_reg, history_next;
    index_t    index_reg;
    logic      taken_reg;

    logic      out_valid_reg, out_valid_next;
    logic      out_pred_reg;
    dp_t       out_dp_reg;
    logic      out_trained_reg;

    logic      accept;
    logic      slot_free;
    logic      finish;
    logic      train;
    sum_ctrl_t sum_ctrl;
    sum_t      sum;
    sum_t      theta;
    dp_t       dp_sat;
    row_t      row_data;
    row_t      new_row;

    logic      ram_we;
    index_t    ram_waddr;
    row_t      ram_wdata;

    assign accept    = branch.valid && branch.ready;
    assign slot_free = !out_valid_reg || result.ready;
    assign finish    = (state_reg == S_UPD) && slot_free;

    always_comb
    begin
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                clr_cnt_next = clr_cnt_reg + index_t'(1);
                if (&clr_cnt_reg)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_READ;
                end
            end
            S_READ:  state_next = S_ACC;
            S_ACC:   state_next = S_UPD;
            S_UPD:
            begin
                if (slot_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_CLEAR;
        endcase
    end

    assign branch.ready = (state_reg == S_IDLE);

    assign sum_ctrl.load_partial = (state_reg == S_READ);
    assign sum_ctrl.load_total   = (state_reg == S_ACC);

    // train unless the sum is confidently on the side of the outcome
    assign theta = sum_t'({{(SUM_W - THR_W){1'b0}}, threshold_reg});
    assign train = taken_reg ? !(sum > theta) : !(sum < -theta);

    always_comb
    begin
        if (sum > sum_t'(DP_MAX))
        begin
            dp_sat = dp_t'(DP_MAX);
        end
        else if (sum < sum_t'(DP_MIN))
        begin
            dp_sat = dp_t'(DP_MIN);
        end
        else
        begin
            dp_sat = dp_t'(sum);
        end
    end

    assign history_next = (history_reg << 1) | hist_t'(taken_reg);

    assign ram_we    = (state_reg == S_CLEAR) || (finish && train);
    assign ram_waddr = (state_reg == S_CLEAR) ? clr_cnt_reg : index_reg;
    assign ram_wdata = (state_reg == S_CLEAR) ? '0 : new_row;

    always_comb
    begin
        if (finish)
        begin
            out_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_cnt_reg   <= '0;
            threshold_reg <= thr_t'(THR_RESET);
            history_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            out_valid_reg <= out_valid_next;
            if (threshold_we)
            begin
                threshold_reg <= threshold_wdata;
            end
            if (finish)
            begin
                history_reg <= history_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            index_reg <= branch.pc[TABLE_INDEX_BITS-1:0];
            taken_reg <= branch.taken;
        end
        if (finish)
        begin
            out_pred_reg    <= !sum[SUM_W-1];
            out_dp_reg      <= dp_sat;
            out_trained_reg <= train;
        end
    end

    pbp_ram #(
        .WIDTH (ROW_W),
        .DEPTH (ROWS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (accept),
        .raddr (branch.pc[TABLE_INDEX_BITS-1:0]),
        .rdata (row_data)
    );

    pbp_sum u_sum (
        .clk  (clk),
        .ctrl (sum_ctrl),
        .row  (row_data),
        .hist (history_reg),
        .sum  (sum)
    );

    pbp_train u_train (
        .row     (row_data),
        .hist    (history_reg),
        .taken   (taken_reg),
        .new_row (new_row)
    );

    assign result.valid           = out_valid_reg;
    assign result.predicted_taken = out_pred_reg;
    assign result.dot_product     = out_dp_reg;
    assign result.trained         = out_trained_reg;

    // an accepted branch always starts with the row read
    a_accept_reads: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg == S_READ)
        else $error("accepted branch did not start a row read");

    // a trained result is written back to the row of its own branch
    a_train_writes: assert property (@(posedge clk) disable iff (!rst_n)
        (finish && train) |-> (ram_we && ram_waddr == index_reg))
        else $error("trained row not written back");

    // result words only come out of the update step
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_UPD))
        else $error("result word without an update step");

    // no branch is taken while the clearing pass runs
    a_clear_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLEAR) |-> (!accept && ram_we && ram_wdata == '0))
        else $error("clearing pass disturbed");
endmodule

>>> bench/tb_perceptron_branch_predictor.sv
// testbench for the perceptron branch predictor: random branch traffic, self-checked verdicts
`timescale 1ns / 100ps

module tb_perceptron_branch_predictor;
    import pbp_pkg::*;

    localparam int W_MAX = (1 << (WEIGHT_BITS - 1)) - 1;
    localparam int W_MIN = -W_MAX - 1;
    localparam int IDLE_LIMIT = 4096;
    localparam int SETTLE_CYCLES = 12;
    localparam int MAX_SHOWN = 10;

    // rows that get steered traffic so their weights run into saturation
    localparam index_t ROW_TAKEN     = index_t'(10'h155);
    localparam index_t ROW_NOT_TAKEN = index_t'(10'h2AA);
    localparam index_t ROW_MIXED     = index_t'(10'h3F0);

    typedef struct {
        pc_t  pc;
        logic taken;
    } branch_t;

    typedef struct packed {
        logic predicted_taken;
        dp_t  dot_product;
        logic trained;
    } verdict_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic threshold_we = 1'b0;
    thr_t threshold_wdata = '0;

    logic br_valid = 1'b0;
    pc_t  br_pc = '0;
    logic br_taken = 1'b0;
    logic res_ready = 1'b0;

    pbp_branch_if br ();
    pbp_result_if res ();

    assign br.valid = br_valid;
    assign br.pc    = br_pc;
    assign br.taken = br_taken;
    assign res.ready = res_ready;

    perceptron_branch_predictor i_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .threshold_we    (threshold_we),
        .threshold_wdata (threshold_wdata),
        .branch          (br),
        .result          (res)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // predictor state
    int       weights [ROWS][ROW_LEN];
    hist_t    history = '0;
    thr_t     theta = thr_t'(THR_RESET);

    branch_t  pending_branches [$];
    verdict_t expected_verdicts [$];
    int       error_count = 0;
    int       shown_count = 0;
    int       idle_cycles = 0;
    int       in_flight = 0;

    function automatic int clamp_weight(int v);
        if (v > W_MAX)
            return W_MAX;
        if (v < W_MIN)
            return W_MIN;
        return v;
    endfunction

    function automatic verdict_t predict_branch(pc_t pc, logic tk);
        index_t   row;
        int       sum;
        int       th;
        int       t;
        int       x;
        int       dp;
        logic     train;
        verdict_t v;
        row = pc[TABLE_INDEX_BITS-1:0];
        th = int'(theta);
        sum = weights[row][0];
        for (int i = 0; i < HISTORY_LEN; i++)
        begin
            if (history[i])
                sum += weights[row][i+1];
            else
                sum -= weights[row][i+1];
        end
        t = tk ? 1 : -1;
        // train unless the sum is confidently on the side of the outcome
        if (tk)
            train = !(sum > th);
        else
            train = !(sum < -th);
        if (train)
        begin
            weights[row][0] = clamp_weight(weights[row][0] + t);
            for (int i = 0; i < HISTORY_LEN; i++)
            begin
                x = history[i] ? 1 : -1;
                weights[row][i+1] = clamp_weight(weights[row][i+1] + t * x);
            end
        end
        history = {history[HISTORY_LEN-2:0], tk};
        dp = sum;
        if (dp > DP_MAX)
            dp = DP_MAX;
        if (dp < DP_MIN)
            dp = DP_MIN;
        v.predicted_taken = (sum >= 0);
        v.dot_product = dp[DP_W-1:0];
        v.trained = train;
        return v;
    endfunction

    // sender: bursts of words with random gaps
    int burst_left = 0;
    int gap_left = 0;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (br_valid && br.ready)
            begin
                expected_verdicts.push_back(predict_branch(br_pc, br_taken));
                in_flight--;
            end
            if (!br_valid || br.ready)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    br_valid <= 1'b0;
                end
                else if (pending_branches.size() > 0)
                begin
                    br_valid <= 1'b1;
                    br_pc <= pending_branches[0].pc;
                    br_taken <= pending_branches[0].taken;
                    void'(pending_branches.pop_front());
                    in_flight++;
                    if (burst_left > 0)
                        burst_left--;
                    if (burst_left == 0)
                    begin
                        if ($urandom_range(7) == 0)
                            burst_left = $urandom_range(30, 60);
                        else
                            burst_left = $urandom_range(1, 12);
                        gap_left = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end
                else
                begin
                    br_valid <= 1'b0;
                end
            end
        end
    end

    // receiver: ready runs and stalls of their own lengths
    int ready_run = 0;
    logic ready_next = 1'b0;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (res.valid && res_ready)
            begin
                if (expected_verdicts.size() == 0)
                begin
                    error_count++;
                    if (shown_count < MAX_SHOWN)
                    begin
                        shown_count++;
                        $display("unexpected result word: pred=%0b dp=%0d trained=%0b",
                                 res.predicted_taken, res.dot_product, res.trained);
                    end
                end
                else
                begin
                    if (res.predicted_taken !== expected_verdicts[0].predicted_taken
                        || res.dot_product !== expected_verdicts[0].dot_product
                        || res.trained !== expected_verdicts[0].trained)
                    begin
                        error_count++;
                        if (shown_count < MAX_SHOWN)
                        begin
                            shown_count++;
                            $display("mismatch: exp pred/dp/trained %0b/%0d/%0b, got %0b/%0d/%0b",
                                     expected_verdicts[0].predicted_taken,
                                     expected_verdicts[0].dot_product,
                                     expected_verdicts[0].trained,
                                     res.predicted_taken, res.dot_product, res.trained);
                        end
                    end
                    void'(expected_verdicts.pop_front());
                end
            end
            if (ready_run == 0)
            begin
                case ($urandom_range(7))
                    0: begin ready_next = 1'b1; ready_run = 40; end
                    1, 2, 3: begin ready_next = 1'b1; ready_run = $urandom_range(1, 20); end
                    default: begin ready_next = 1'b0; ready_run = $urandom_range(1, 6); end
                endcase
            end
            ready_run--;
            res_ready <= ready_next;
        end
    end

    // watchdog on cycles without any accepted word
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((br_valid && br.ready) || (res.valid && res_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("tb_perceptron_branch_predictor: errors");
                $finish;
            end
        end
    end

    task automatic add_branch(pc_t pc, logic tk);
        branch_t b;
        b.pc = pc;
        b.taken = tk;
        pending_branches.push_back(b);
    endtask

    // random traffic; hot_pct of it goes to the steered rows
    task automatic add_traffic(int n, int hot_pct);
        pc_t  pc;
        logic tk;
        for (int k = 0; k < n; k++)
        begin
            pc = {$urandom, $urandom};
            tk = 1'($urandom_range(1));
            if ($urandom_range(99) < hot_pct)
            begin
                case ($urandom_range(9))
                    0, 1, 2, 3: begin pc[TABLE_INDEX_BITS-1:0] = ROW_TAKEN; tk = 1'b1; end
                    4, 5, 6, 7: begin pc[TABLE_INDEX_BITS-1:0] = ROW_NOT_TAKEN; tk = 1'b0; end
                    default: pc[TABLE_INDEX_BITS-1:0] = ROW_MIXED + index_t'($urandom_range(3));
                endcase
            end
            add_branch(pc, tk);
        end
    endtask

    task automatic wait_idle();
        @(negedge clk);
        while (pending_branches.size() != 0 || in_flight != 0 || expected_verdicts.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_threshold(thr_t v);
        @(posedge clk);
        threshold_we <= 1'b1;
        threshold_wdata <= v;
        theta = v;
        @(posedge clk);
        threshold_we <= 1'b0;
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // directed: address extremes, both outcomes, repeated rows, reset threshold
        add_branch(64'h0, 1'b0);
        add_branch(64'h0, 1'b1);
        add_branch(64'hFFFF_FFFF_FFFF_FFFF, 1'b1);
        add_branch(64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
        add_branch(64'h8000_0000_0000_0000, 1'b1);
        add_branch(64'h0000_0000_0000_03FF, 1'b0);
        add_branch(64'hFFFF_FFFF_FFFF_FC00, 1'b1);
        add_branch(64'h5555_5555_5555_5555, 1'b1);
        add_branch(64'hAAAA_AAAA_AAAA_AAAA, 1'b0);
        add_branch(64'h5555_5555_5555_5555, 1'b0);
        add_branch(64'hAAAA_AAAA_AAAA_AAAA, 1'b1);
        for (int k = 0; k < 6; k++)
            add_branch(64'h0000_0000_0000_0001, 1'b1);
        add_branch(64'h0000_0000_0000_0001, 1'b0);
        add_branch(64'h1234_5678_9ABC_DEF0, 1'b1);
        add_branch(64'h0000_0000_0000_0400, 1'b0);
        wait_idle();

        // zero threshold: trains only on a wrong sign or a zero sum
        write_threshold('0);
        add_traffic(100, 60);
        wait_idle();

        // largest threshold: steered rows saturate their weights
        write_threshold('1);
        add_traffic(360, 95);
        wait_idle();

        write_threshold(thr_t'($urandom_range(2, 1021)));
        add_traffic(80, 50);
        wait_idle();

        write_threshold(thr_t'(1));
        add_traffic(60, 70);
        wait_idle();

        if (error_count == 0)
            $display("tb_perceptron_branch_predictor: clean");
        else
            $display("tb_perceptron_branch_predictor: errors");
        $finish;
    end

endmodule

>>> perceptron_branch_predictor.f
design/pbp_pkg.sv
design/pbp_if.sv
design/pbp_ram.sv
design/pbp_sum.sv
design/pbp_train.sv
design/perceptron_branch_predictor.sv
bench/tb_perceptron_branch_predictor.sv
